FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files of the index exchange sort.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, suspended during reset.
`define IES_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that stays active during reset.
`define IES_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/iesort_pkg.sv
// Shared types and fixed field widths of the index exchange sort.
// No dependencies.
package iesort_pkg;

  localparam int VAL_W = 16;
  localparam int POS_W = 6;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;

endpackage

FILE: sv/iesort_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered reads.
// No dependencies.
module iesort_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

FILE: sv/index_exchange_sort.sv
// Index exchange sort: one word is loaded per cycle while in_stall is low; after the final
// word each outer pass fetches the head entry, scans the later positions through the single
// order-list port that feeds one compare per cycle, then drains the compare pipeline.
// Results then leave one word at a time (order read, value read, output register).
// Reset is synchronous, active high: it clears the control state and the output valid;
// the two memories are not cleared, and only entries loaded for the current set are read.
module index_exchange_sort #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  iesort_pkg::value_t   sample_value,
  input  logic                 is_final,
  input  logic                 in_valid,
  output logic                 in_stall,
  output iesort_pkg::pos_t     original_position,
  output iesort_pkg::value_t   sorted_value,
  output logic                 run_end,
  output logic                 out_valid,
  input  logic                 out_stall
);

  // Index width into the stores, and count width that can hold MAX_ITEMS itself.
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  // The controller walks through load, sort and emit phases. Each outer pass of the
  // exchange sort fetches the head entry (order read, then value read), then streams
  // the later positions through a two-stage read pipeline into a single compare.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_HEAD_RD,
    ST_HEAD_IDX,
    ST_HEAD_VAL,
    ST_SCAN,
    ST_DRAIN,
    ST_WRHEAD,
    ST_EMIT_RD,
    ST_EMIT_IDX,
    ST_EMIT_OUT
  } state_t;

  state_t state;

  logic [CW-1:0] cnt;       // words loaded into the current set
  logic [CW-1:0] n;         // size of the set being sorted and emitted
  logic [IW-1:0] pos;       // outer position of the exchange sort
  logic [IW-1:0] lst;       // next later position to issue
  logic [IW-1:0] k;         // rank being emitted
  logic [IW-1:0] cur_idx;   // index currently held for position pos
  iesort_pkg::value_t cur_val;  // value that cur_idx points at
  logic [IW-1:0] emit_idx;

  // Compare pipeline: stage 1 has the order word, stage 2 has the value word.
  logic          s1_v, s2_v;
  logic [IW-1:0] s1_l, s2_l, s2_idx;

  // Memory ports.
  logic          ord_we, ord_re, val_we, val_re;
  logic [IW-1:0] ord_wa, ord_wd, ord_ra, ord_rd, val_wa, val_ra;
  iesort_pkg::value_t val_wd, val_rd;

  logic in_acc, has_room, swap, out_free, emit_last;
  logic [CW-1:0] n_load;

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign has_room = (cnt < CW'(MAX_ITEMS));
  // A full set drops the word, but a dropped final word still starts the sort.
  assign n_load   = has_room ? cnt + CW'(1) : cnt;

  // Strictly greater: equal values are never exchanged.
  assign swap      = s2_v && (cur_val > val_rd);
  assign out_free  = !out_valid || !out_stall;
  assign emit_last = (CW'(k) == n - CW'(1));

  // Value store: written on load, read for the head, the pipeline and emission.
  assign val_we = in_acc && has_room;
  assign val_wa = cnt[IW-1:0];
  assign val_wd = sample_value;

  always_comb begin
    val_re = 1'b0;
    val_ra = ord_rd;
    if (state == ST_HEAD_IDX || state == ST_EMIT_IDX || s1_v) begin
      val_re = 1'b1;
    end
  end

  // Order list: the load, a swap in the compare stage and the head write-back never
  // fall in the same cycle, so one write port serves all three.
  always_comb begin
    ord_we = 1'b0;
    ord_wa = cnt[IW-1:0];
    ord_wd = cnt[IW-1:0];
    if (in_acc && has_room) begin
      ord_we = 1'b1;
    end else if (swap) begin
      ord_we = 1'b1;
      ord_wa = s2_l;
      ord_wd = cur_idx;
    end else if (state == ST_WRHEAD) begin
      ord_we = 1'b1;
      ord_wa = pos;
      ord_wd = cur_idx;
    end
  end

  always_comb begin
    ord_re = 1'b0;
    ord_ra = lst;
    case (state)
      ST_HEAD_RD: begin
        ord_re = 1'b1;
        ord_ra = pos;
      end
      ST_SCAN: begin
        ord_re = 1'b1;
        ord_ra = lst;
      end
      ST_EMIT_RD: begin
        ord_re = 1'b1;
        ord_ra = k;
      end
      default: begin
        ord_re = 1'b0;
      end
    endcase
  end

  iesort_ram #(
    .WIDTH (iesort_pkg::VAL_W),
    .DEPTH (MAX_ITEMS)
  ) u_val_ram (
    .clk (clk),
    .we  (val_we),
    .wa  (val_wa),
    .wd  (val_wd),
    .re  (val_re),
    .ra  (val_ra),
    .rd  (val_rd)
  );

  iesort_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_ITEMS)
  ) u_ord_ram (
    .clk (clk),
    .we  (ord_we),
    .wa  (ord_wa),
    .wd  (ord_wd),
    .re  (ord_re),
    .ra  (ord_ra),
    .rd  (ord_rd)
  );

  // Pipeline payload needs no reset.
  always_ff @(posedge clk) begin
    s1_l   <= lst;
    s2_l   <= s1_l;
    s2_idx <= ord_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v <= (state == ST_SCAN);
      s2_v <= s1_v;

      // A taken word clears valid unless the emit stage loads the next one.
      if (out_valid && !out_stall && state != ST_EMIT_OUT) begin
        out_valid <= 1'b0;
      end

      // A swap moves the later index into the head slot held in registers.
      if (swap) begin
        cur_idx <= s2_idx;
        cur_val <= val_rd;
      end

      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              cnt <= cnt + CW'(1);
            end
            if (is_final) begin
              n   <= n_load;
              pos <= '0;
              k   <= '0;
              state <= (n_load == CW'(1)) ? ST_EMIT_RD : ST_HEAD_RD;
            end
          end
        end
        ST_HEAD_RD: begin
          lst   <= pos + IW'(1);
          state <= ST_HEAD_IDX;
        end
        ST_HEAD_IDX: begin
          cur_idx <= ord_rd;
          state   <= ST_HEAD_VAL;
        end
        ST_HEAD_VAL: begin
          cur_val <= val_rd;
          state   <= ST_SCAN;
        end
        ST_SCAN: begin
          if (CW'(lst) == n - CW'(1)) begin
            state <= ST_DRAIN;
          end else begin
            lst <= lst + IW'(1);
          end
        end
        ST_DRAIN: begin
          // The last compare of the pass has finished once both stages are empty.
          if (!s1_v && !s2_v) begin
            state <= ST_WRHEAD;
          end
        end
        ST_WRHEAD: begin
          if (CW'(pos) + CW'(2) < n) begin
            pos   <= pos + IW'(1);
            state <= ST_HEAD_RD;
          end else begin
            k     <= '0;
            state <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_IDX;
        end
        ST_EMIT_IDX: begin
          emit_idx <= ord_rd;
          state    <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          // The value word holds while no new read is issued, so this can wait.
          if (out_free) begin
            out_valid         <= 1'b1;
            original_position <= iesort_pkg::POS_W'(emit_idx);
            sorted_value      <= val_rd;
            run_end           <= emit_last;
            if (emit_last) begin
              cnt   <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + IW'(1);
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

FILE: sv/iesort_checker.sv
// Port-level checker for the index exchange sort, bound to the top level.
// Depends on iesort_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iesort_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input iesort_pkg::pos_t     original_position,
  input iesort_pkg::value_t   sorted_value,
  input logic                 run_end,
  input logic                 out_valid,
  input logic                 out_stall
);

  logic               out_acc;
  logic               held;
  logic               in_order;
  logic               mid_run;
  iesort_pkg::value_t prev_value;
  logic [iesort_pkg::POS_W+iesort_pkg::VAL_W:0] out_word;

  assign out_acc  = out_valid && !out_stall;
  assign held     = out_valid && out_stall;
  assign in_order = (sorted_value >= prev_value);
  assign out_word = {original_position, sorted_value, run_end};

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_run <= 1'b0;
    end else if (out_acc) begin
      mid_run <= !run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_value <= sorted_value;
    end
  end

  `IES_ASSERT_NR(a_idle_after_rst, clk, rst |=> !out_valid, "output valid after reset")
  `IES_ASSERT(a_valid_holds, clk, rst, held |=> out_valid, "valid dropped")
  `IES_ASSERT(a_word_holds, clk, rst, held |=> $stable(out_word), "stalled word changed")
  `IES_ASSERT(a_ascending, clk, rst, out_acc && mid_run |-> in_order, "run not ascending")
  `IES_ASSERT(a_busy_in_run, clk, rst, out_valid && !run_end |-> in_stall, "input taken mid-run")

endmodule

bind index_exchange_sort iesort_checker u_iesort_checker (.*);

FILE: test/index_exchange_sort_tb.sv
// Self-checking testbench for index_exchange_sort: sends sets of signed samples, predicts the
// sorted run of (arrival index, value) pairs for each set and checks every result word.
// Depends on iesort_pkg and the index_exchange_sort module.
module index_exchange_sort_tb;

  // The block is used at its default capacity.
  localparam int SET_CAPACITY = 64;

  // A generous bound on the whole run. The slowest legal run is dominated by the sort of
  // the full set and by the hold-off.
  localparam int CYCLE_LIMIT = 400000;

  // Cycles allowed after the last expected word, in case a stray word is still on its way.
  localparam int TAIL_CYCLES = 50;

  // How long the receiver holds off in the backpressure test.
  localparam int HOLD_CYCLES = 3000;

  // One result word: which arrival index sits at this rank, its value, and the run end flag.
  typedef struct packed {
    iesort_pkg::pos_t   position;
    iesort_pkg::value_t value;
    logic               last;
  } sorted_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  iesort_pkg::value_t sample_value = '0;
  logic               is_final = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  iesort_pkg::pos_t   original_position;
  iesort_pkg::value_t sorted_value;
  logic               run_end;
  logic               out_valid;
  logic               out_stall = 1'b0;

  index_exchange_sort i_dut (
    .clk               (clk),
    .rst               (rst),
    .sample_value      (sample_value),
    .is_final          (is_final),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .original_position (original_position),
    .sorted_value      (sorted_value),
    .run_end           (run_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall)
  );

  always #4 clk = ~clk;

  // Our own copy of the block's state: the samples at their arrival slots, the index list
  // that gets sorted, and how many slots of the current set are filled.
  iesort_pkg::value_t sample_slots [SET_CAPACITY];
  iesort_pkg::pos_t   index_list [SET_CAPACITY];
  int                 slots_filled = 0;

  // Sorted words that the block still owes us, oldest first.
  sorted_word_t pending_sorted [$];

  int error_count = 0;
  int runs_sorted = 0;
  int words_checked = 0;
  int words_dropped = 0;
  int cycle_count = 0;

  // Idle controls. The sender reads tx_gaps in its own process; the stall process reads
  // rx_gaps and hold_on, both of which change only with nonblocking assignments.
  bit   tx_gaps = 1'b1;
  logic rx_gaps = 1'b1;
  logic hold_on = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Accept one sample into the predicted state. A final word closes the set: the index list
  // is put in order with the same exchange sort the block uses, so that equal values end up
  // in exactly the order the block produces, and one expected word per slot is queued.
  function automatic void predict_sorted_run(input iesort_pkg::value_t v, input logic fin);
    iesort_pkg::pos_t swap_tmp;
    sorted_word_t     w;
    if (slots_filled < SET_CAPACITY) begin
      sample_slots[slots_filled] = v;
      index_list[slots_filled] = iesort_pkg::pos_t'(slots_filled);
      slots_filled++;
    end else begin
      words_dropped++;
    end
    if (!fin) return;
    for (int p = 0; p + 1 < slots_filled; p++) begin
      for (int q = p + 1; q < slots_filled; q++) begin
        if (sample_slots[index_list[p]] > sample_slots[index_list[q]]) begin
          swap_tmp = index_list[p];
          index_list[p] = index_list[q];
          index_list[q] = swap_tmp;
        end
      end
    end
    for (int k = 0; k < slots_filled; k++) begin
      w.position = index_list[k];
      w.value = sample_slots[index_list[k]];
      w.last = (k == slots_filled - 1);
      pending_sorted.push_back(w);
    end
    slots_filled = 0;
    runs_sorted++;
  endfunction

  // Offer one word and hold it until the block takes it. This is entered at a rising edge;
  // a gap lowers valid at one edge and raises it at the next one, never at the same edge.
  task automatic send_word(input iesort_pkg::value_t v, input logic fin);
    if (tx_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    is_final <= fin;
    do @(posedge clk); while (in_stall);
    predict_sorted_run(v, fin);
  endtask

  // Stop offering and wait until every predicted word has come back. The loop waits on the
  // clock before it checks the queue, so a following send never lowers and raises valid at once.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_sorted.size() != 0);
  endtask

  // Mostly full range values, with a share of tiny values to force ties and a share of
  // the two extremes of the signed range.
  function automatic iesort_pkg::value_t pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) return iesort_pkg::value_t'(int'($urandom_range(4)) - 2);
    if (sel < 35) begin
      return $urandom_range(1) ? iesort_pkg::value_t'(16'h8000)
                               : iesort_pkg::value_t'(16'h7FFF);
    end
    return iesort_pkg::value_t'($urandom());
  endfunction

  // Receiver hold-off, counted in its own process while the sender keeps going.
  task automatic hold_receiver(input int cycles);
    hold_on <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  // Output stall: forced in a hold-off; with rx_gaps set, random about one cycle in five.
  always @(posedge clk) begin
    out_stall <= hold_on | (rx_gaps && $urandom_range(99) < 19);
  end

  // Result checker. Every word the block hands over is compared against the oldest
  // expectation; a word with nothing waiting is itself a failure.
  always @(posedge clk) begin
    sorted_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected word index=%0d value=%0d end=%0b",
                                  original_position, sorted_value, run_end));
      end else begin
        exp_w = pending_sorted.pop_front();
        words_checked++;
        if (original_position !== exp_w.position)
          report_mismatch($sformatf("original_position %0d, expected %0d",
                                    original_position, exp_w.position));
        if (sorted_value !== exp_w.value)
          report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                    sorted_value, exp_w.value));
        if (run_end !== exp_w.last)
          report_mismatch($sformatf("run_end %0b, expected %0b", run_end, exp_w.last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               pending_sorted.size());
      $display("index_exchange_sort verification failed");
      $finish;
    end
  end

  // A set of one: the run is a single word with the end flag set.
  task automatic test_single_word();
    send_word(iesort_pkg::value_t'(16'h8000), 1'b1);
    wait_for_results();
  endtask

  // Both ends of the signed range, zero, the values next to zero and alternating bit
  // patterns, so that every bit of the sample is seen at both levels.
  task automatic test_extremes();
    iesort_pkg::value_t vals [7];
    vals = '{iesort_pkg::value_t'(16'h7FFF), iesort_pkg::value_t'(16'h8000),
             iesort_pkg::value_t'(16'h0000), iesort_pkg::value_t'(16'hFFFF),
             iesort_pkg::value_t'(16'h0001), iesort_pkg::value_t'(16'h5555),
             iesort_pkg::value_t'(16'hAAAA)};
    foreach (vals[i]) send_word(vals[i], i == 6);
    wait_for_results();
  endtask

  // Repeated values are never swapped with each other by the compare, but the exchange
  // sort can still move them past one another; the predicted order catches either fault.
  task automatic test_equal_values();
    iesort_pkg::value_t vals [5];
    vals = '{iesort_pkg::value_t'(5), iesort_pkg::value_t'(-3), iesort_pkg::value_t'(5),
             iesort_pkg::value_t'(5), iesort_pkg::value_t'(-3)};
    foreach (vals[i]) send_word(vals[i], i == 4);
    wait_for_results();
  endtask

  // Strictly descending input, so every compare swaps.
  task automatic test_descending();
    for (int i = 0; i < 4; i++) send_word(iesort_pkg::value_t'(3 - i), i == 3);
    wait_for_results();
  endtask

  // Fill a set to capacity, then offer one more plain word and a final word; both are
  // dropped, and the final one still starts the sort. While the receiver is held off the
  // sender goes straight on with a short set, so the finished run backs up in the block
  // and the block has to stall its input.
  task automatic test_full_set_backpressure();
    fork
      hold_receiver(HOLD_CYCLES);
    join_none
    for (int i = 0; i < SET_CAPACITY; i++) send_word(pick_value(), 1'b0);
    send_word(pick_value(), 1'b0);
    send_word(pick_value(), 1'b1);
    for (int i = 0; i < 5; i++) send_word(pick_value(), i == 4);
    wait_for_results();
  endtask

  // A long stretch with no idling on either side, sets back to back.
  task automatic test_steady_stream();
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < 8; i++) send_word(pick_value(), i == 7);
    end
    wait_for_results();
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;
  endtask

  // Random sets, mostly short ones with the occasional longer one, sent back to back.
  task automatic test_random_sets();
    int words_sent;
    int set_len;
    words_sent = 0;
    while (words_sent < 12) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 8);
      for (int i = 0; i < set_len; i++) send_word(pick_value(), i == set_len - 1);
      words_sent += set_len;
    end
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_word();
    test_extremes();
    test_equal_values();
    test_descending();
    test_full_set_backpressure();
    test_steady_stream();
    test_random_sets();

    // Everything has been accepted and answered; give any stray word time to show up.
    in_valid <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_sorted.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", pending_sorted.size()));

    $display("Covered %0d sorted runs with %0d result words checked,", runs_sorted,
             words_checked);
    $display("including %0d words dropped at a full set and a long receiver hold-off.",
             words_dropped);
    if (error_count == 0) begin
      $display("index_exchange_sort verification clean");
    end else begin
      $display("index_exchange_sort verification failed");
    end
    $finish;
  end

endmodule
